>>> sv/rk4dp_pkg.sv
// rk4dp_pkg: shared types, fixed-point constants and rounding helpers
// for the rk4 damped pendulum step core; no dependencies
`default_nettype none

package rk4dp_pkg;

   localparam int FRAC_BITS = 16;

   localparam longint Q_ONE      = 64'sd1 <<< FRAC_BITS;
   localparam longint Q_TWO_PI   = ((longint'(105414357) * 2 >>> (24 - FRAC_BITS)) + 1) >>> 1;
   localparam longint Q_PI       = ((longint'(52707179) * 2 >>> (24 - FRAC_BITS)) + 1) >>> 1;
   localparam longint Q_HALF_PI  = ((longint'(26353589) * 2 >>> (24 - FRAC_BITS)) + 1) >>> 1;

   // offset that makes any 33-bit angle difference non-negative, multiple of two pi
   localparam longint RED_OFFSET = Q_TWO_PI * (((64'sd1 <<< 32) + Q_TWO_PI - 1) / Q_TWO_PI);
   localparam int     RED_STEPS  = 15;

   localparam int     RECIP_SHIFT = 32;
   localparam longint RECIP_72    = ((64'sd1 <<< RECIP_SHIFT) + 71) / 72;
   localparam longint RECIP_42    = ((64'sd1 <<< RECIP_SHIFT) + 41) / 42;
   localparam longint RECIP_20    = ((64'sd1 <<< RECIP_SHIFT) + 19) / 20;
   localparam longint RECIP_6     = ((64'sd1 <<< RECIP_SHIFT) + 5) / 6;

   localparam int     DIV6_SHIFT  = 37;
   localparam longint RECIP6_WIDE = ((64'sd1 <<< DIV6_SHIFT) + 5) / 6;

   typedef logic signed [31:0] q_type;

   typedef enum logic [2:0] {
      CSR_STEP_SIZE   = 3'd0,
      CSR_GOAL_ANGLE  = 3'd1,
      CSR_STIFFNESS   = 3'd2,
      CSR_DAMPING     = 3'd3,
      CSR_GRAVITY     = 3'd4,
      CSR_TORQUE_GAIN = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [30:0] step_size;
      q_type       goal_angle;
      logic [30:0] stiffness_ratio;
      logic [30:0] damping_ratio;
      logic [30:0] gravity_ratio;
      q_type       torque_gain;
   } cfg_type;

   typedef struct packed {
      q_type a0;
      q_type v0;
      q_type tq;
      q_type dv1;
      q_type dv2;
      q_type dv3;
      q_type da2;
      q_type da3;
      q_type da4;
   } carry_type;

   typedef struct packed {
      q_type     k;
      q_type     dm;
      carry_type c;
   } sin_side_type;

   function automatic q_type sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -66'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   // round half up, floor shift, saturate; half selects the extra shift of h/2
   function automatic q_type qround(input logic signed [65:0] p, input logic half);
      logic signed [65:0] r;
      if (half) begin
         r = (p + (66'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
      end else begin
         r = (p + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      end
      return sat32(r);
   endfunction

endpackage

`default_nettype wire

>>> sv/rk4dp_if.sv
// rk4dp request and response channel interfaces
// valid/ready handshake with q16.16 payload; no dependencies
`default_nettype none

interface rk4dp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle_in;
   logic signed [31:0] velocity_in;
   logic signed [31:0] torque_in;

   modport source (output valid, angle_in, velocity_in, torque_in, input ready);
   modport sink (input valid, angle_in, velocity_in, torque_in, output ready);
endinterface

interface rk4dp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle_out;
   logic signed [31:0] velocity_out;

   modport source (output valid, angle_out, velocity_out, input ready);
   modport sink (input valid, angle_out, velocity_out, output ready);
endinterface

`default_nettype wire

>>> sv/rk4dp_sin.sv
// rk4dp_sin: 16-stage sine pipeline, range reduction by compare-subtract
// then folded horner series; depends on rk4dp_pkg
`default_nettype none

module rk4dp_sin
   import rk4dp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               valid_in,
   input  wire logic signed [32:0] d_in,
   input  wire sin_side_type       side_in,
   output logic                    valid_out,
   output q_type                   sin_out,
   output sin_side_type            side_out
);

   localparam int NST = 16;
   localparam int NHZ = 10;

   typedef struct packed {
      logic signed [17:0] x;
      logic [17:0]        x2;
      logic signed [49:0] acc;
   } hz_type;

   function automatic logic [33:0] red_steps(input logic [33:0] x, input int hi, input int lo);
      logic [33:0] r;
      logic [33:0] c;
      r = x;
      for (int j = RED_STEPS - 1; j >= 0; j--) begin
         c = 34'(Q_TWO_PI) << j;
         if (j <= hi && j >= lo && r >= c) begin
            r = r - c;
         end
      end
      return r;
   endfunction

   function automatic logic signed [49:0] r16(input logic signed [49:0] p);
      return (p + (50'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   logic [NST-1:0]     vld_ff;
   sin_side_type       side_ff [NST];
   logic [33:0]        u_ff;
   logic [33:0]        red_ff [4];
   logic signed [17:0] x_ff;
   hz_type             hz_ff [NHZ];
   hz_type             hz_in [NHZ];
   logic signed [19:0] fold_in;
   logic signed [49:0] n;
   logic [16:0]        t;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < NST; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         u_ff <= {d_in[32], d_in} + 34'(RED_OFFSET);
         red_ff[0] <= red_steps(u_ff, 14, 11);
         red_ff[1] <= red_steps(red_ff[0], 10, 7);
         red_ff[2] <= red_steps(red_ff[1], 6, 3);
         red_ff[3] <= red_steps(red_ff[2], 2, 0);
         x_ff <= fold_in[17:0];
         for (int i = 0; i < NHZ; i++) begin
            hz_ff[i] <= hz_in[i];
         end
      end
   end

   // fold into [-pi/2, pi/2]
   always_comb begin
      fold_in = $signed({1'b0, red_ff[3][18:0]});
      if (fold_in > 20'(Q_PI)) begin
         fold_in = fold_in - 20'(Q_TWO_PI);
      end
      if (fold_in > 20'(Q_HALF_PI)) begin
         fold_in = 20'(Q_PI) - fold_in;
      end else if (fold_in < -20'(Q_HALF_PI)) begin
         fold_in = -20'(Q_PI) - fold_in;
      end
   end

   // horner series, at most one multiply per stage
   always_comb begin
      n = '0;
      t = '0;
      hz_in[0].x   = x_ff;
      hz_in[0].x2  = '0;
      hz_in[0].acc = 50'(x_ff) * 50'(x_ff);
      for (int k = 1; k < NHZ; k++) begin
         hz_in[k] = hz_ff[k-1];
      end
      n = r16(hz_ff[0].acc);
      hz_in[1].x2  = n[17:0];
      hz_in[1].acc = 50'($signed({1'b0, n[17:0]})) * 50'(RECIP_72);
      for (int k = 2; k <= 6; k += 2) begin
         t = 17'(Q_ONE) - 17'(hz_ff[k-1].acc >>> RECIP_SHIFT);
         hz_in[k].acc = 50'($signed({1'b0, hz_ff[k-1].x2})) * 50'($signed({1'b0, t}));
      end
      n = r16(hz_ff[2].acc);
      hz_in[3].acc = 50'($signed({1'b0, n[17:0]})) * 50'(RECIP_42);
      n = r16(hz_ff[4].acc);
      hz_in[5].acc = 50'($signed({1'b0, n[17:0]})) * 50'(RECIP_20);
      n = r16(hz_ff[6].acc);
      hz_in[7].acc = 50'($signed({1'b0, n[17:0]})) * 50'(RECIP_6);
      t = 17'(Q_ONE) - 17'(hz_ff[7].acc >>> RECIP_SHIFT);
      hz_in[8].acc = 50'(hz_ff[7].x) * 50'($signed({1'b0, t}));
      hz_in[9].acc = r16(hz_ff[8].acc);
   end

   assign valid_out = vld_ff[NST-1];
   assign sin_out   = hz_ff[NHZ-1].acc[31:0];
   assign side_out  = side_ff[NST-1];

endmodule

`default_nettype wire

>>> sv/rk4dp_accel.sv
// rk4dp_accel: 21-stage pendulum acceleration, spring, damper, torque and
// gravity terms; depends on rk4dp_pkg and rk4dp_sin
`default_nettype none

module rk4dp_accel
   import rk4dp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      en,
   input  wire cfg_type   cfg,
   input  wire logic      valid_in,
   input  wire q_type     a_in,
   input  wire q_type     v_in,
   input  wire carry_type carry_in,
   output logic           valid_out,
   output q_type          acc_out,
   output carry_type      carry_out
);

   logic [2:0]         pre_vld_ff;
   logic [1:0]         post_vld_ff;
   logic signed [32:0] d1_ff, d2_ff, d3_ff;
   q_type              ks1_ff, v1_ff;
   logic signed [65:0] kp2_ff, dp2_ff, gp4_ff;
   sin_side_type       side1_ff, side2_ff, side3_ff, side4_ff;
   sin_side_type       sin_side;
   logic               sin_valid;
   q_type              sin_val;
   q_type              acc5_ff;
   carry_type          c5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff  <= '0;
         post_vld_ff <= '0;
      end else if (en) begin
         pre_vld_ff  <= {pre_vld_ff[1:0], valid_in};
         post_vld_ff <= {post_vld_ff[0], sin_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff      <= 33'(a_in) - 33'(cfg.goal_angle);
         ks1_ff     <= sat32(66'(cfg.goal_angle) - 66'(a_in));
         v1_ff      <= v_in;
         side1_ff   <= '{k: '0, dm: '0, c: carry_in};
         d2_ff      <= d1_ff;
         kp2_ff     <= 66'(ks1_ff) * 66'($signed({1'b0, cfg.stiffness_ratio}));
         dp2_ff     <= 66'(v1_ff) * 66'($signed({1'b0, cfg.damping_ratio}));
         side2_ff   <= side1_ff;
         d3_ff      <= d2_ff;
         side3_ff   <= '{k: qround(kp2_ff, 1'b0), dm: qround(dp2_ff, 1'b0), c: side2_ff.c};
         gp4_ff     <= 66'($signed({1'b0, cfg.gravity_ratio})) * 66'(sin_val);
         side4_ff   <= sin_side;
         acc5_ff    <= sat32(-66'(qround(gp4_ff, 1'b0)) - 66'(side4_ff.c.tq)
                             + 66'(side4_ff.k) - 66'(side4_ff.dm));
         c5_ff      <= side4_ff.c;
      end
   end

   rk4dp_sin u_sin (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (pre_vld_ff[2]),
      .d_in      (d3_ff),
      .side_in   (side3_ff),
      .valid_out (sin_valid),
      .sin_out   (sin_val),
      .side_out  (sin_side)
   );

   assign valid_out = post_vld_ff[1];
   assign acc_out   = acc5_ff;
   assign carry_out = c5_ff;

endmodule

`default_nettype wire

>>> sv/rk4dp_advance.sv
// rk4dp_advance: 3-stage intermediate state for the next rk4 slope,
// products with h (or h/2), rounding, saturating add; depends on rk4dp_pkg
`default_nettype none

module rk4dp_advance
   import rk4dp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      en,
   input  wire cfg_type   cfg,
   input  wire logic      half,
   input  wire logic      valid_in,
   input  wire q_type     dv_in,
   input  wire q_type     dap_in,
   input  wire carry_type carry_in,
   output logic           valid_out,
   output q_type          a_out,
   output q_type          da_out,
   output carry_type      carry_out
);

   logic [2:0]         vld_ff;
   logic signed [65:0] pv1_ff, pa1_ff;
   q_type              rv2_ff, ra2_ff, a3_ff, da3_ff;
   carry_type          c1_ff, c2_ff, c3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pv1_ff <= 66'(dv_in) * 66'($signed({1'b0, cfg.step_size}));
         pa1_ff <= 66'(dap_in) * 66'($signed({1'b0, cfg.step_size}));
         c1_ff  <= carry_in;
         rv2_ff <= qround(pv1_ff, half);
         ra2_ff <= qround(pa1_ff, half);
         c2_ff  <= c1_ff;
         da3_ff <= sat32(66'(c2_ff.v0) + 66'(rv2_ff));
         a3_ff  <= sat32(66'(c2_ff.a0) + 66'(ra2_ff));
         c3_ff  <= c2_ff;
      end
   end

   assign valid_out = vld_ff[2];
   assign a_out     = a3_ff;
   assign da_out    = da3_ff;
   assign carry_out = c3_ff;

endmodule

`default_nettype wire

>>> sv/rk4dp_final.sv
// rk4dp_final: 7-stage weighted slope sum, divide by six by reciprocal,
// product with h and saturating update; last stage is the output register
`default_nettype none

module rk4dp_final
   import rk4dp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      en,
   input  wire cfg_type   cfg,
   input  wire logic      valid_in,
   input  wire q_type     dv4_in,
   input  wire carry_type carry_in,
   output logic           valid_out,
   output q_type          a_out,
   output q_type          v_out
);

   localparam int HW = 17;

   logic [6:0]         vld_ff;
   carry_type          c_ff [6];
   logic signed [35:0] sa1_ff, sv1_ff;
   logic               nega2_ff, negv2_ff, nega3_ff, negv3_ff;
   logic [33:0]        maga2_ff, magv2_ff;
   logic [51:0]        pha3_ff, pla3_ff, phv3_ff, plv3_ff;
   logic signed [32:0] qa4_ff, qv4_ff;
   logic signed [65:0] pa5_ff, pv5_ff;
   q_type              ra6_ff, rv6_ff, a7_ff, v7_ff;
   logic [69:0]        suma, sumv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], valid_in};
      end
   end

   always_comb begin
      suma = (70'(pha3_ff) << HW) + 70'(pla3_ff);
      sumv = (70'(phv3_ff) << HW) + 70'(plv3_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff[0] <= carry_in;
         for (int i = 1; i < 6; i++) begin
            c_ff[i] <= c_ff[i-1];
         end
         sa1_ff <= 36'(carry_in.v0) + (36'(carry_in.da2) <<< 1)
                   + (36'(carry_in.da3) <<< 1) + 36'(carry_in.da4);
         sv1_ff <= 36'(carry_in.dv1) + (36'(carry_in.dv2) <<< 1)
                   + (36'(carry_in.dv3) <<< 1) + 36'(dv4_in);
         nega2_ff <= sa1_ff[35];
         negv2_ff <= sv1_ff[35];
         maga2_ff <= sa1_ff[35] ? 34'(-sa1_ff) : 34'(sa1_ff);
         magv2_ff <= sv1_ff[35] ? 34'(-sv1_ff) : 34'(sv1_ff);
         nega3_ff <= nega2_ff;
         negv3_ff <= negv2_ff;
         pha3_ff  <= 52'(maga2_ff[33:HW]) * 52'(RECIP6_WIDE);
         pla3_ff  <= 52'(maga2_ff[HW-1:0]) * 52'(RECIP6_WIDE);
         phv3_ff  <= 52'(magv2_ff[33:HW]) * 52'(RECIP6_WIDE);
         plv3_ff  <= 52'(magv2_ff[HW-1:0]) * 52'(RECIP6_WIDE);
         qa4_ff   <= nega3_ff ? -$signed(33'(suma >> DIV6_SHIFT))
                              : $signed(33'(suma >> DIV6_SHIFT));
         qv4_ff   <= negv3_ff ? -$signed(33'(sumv >> DIV6_SHIFT))
                              : $signed(33'(sumv >> DIV6_SHIFT));
         pa5_ff   <= 66'(qa4_ff) * 66'($signed({1'b0, cfg.step_size}));
         pv5_ff   <= 66'(qv4_ff) * 66'($signed({1'b0, cfg.step_size}));
         ra6_ff   <= qround(pa5_ff, 1'b0);
         rv6_ff   <= qround(pv5_ff, 1'b0);
         a7_ff    <= sat32(66'(c_ff[5].a0) + 66'(ra6_ff));
         v7_ff    <= sat32(66'(c_ff[5].v0) + 66'(rv6_ff));
      end
   end

   assign valid_out = vld_ff[6];
   assign a_out     = a7_ff;
   assign v_out     = v7_ff;

endmodule

`default_nettype wire

>>> sv/rk4_damped_pendulum_step_core.sv
// rk4_damped_pendulum_step_core: one rk4 step of a spring-damper pendulum
// through input registers, four 21-stage acceleration units, three advance
// units and the final unit in series; one item per cycle sustained while
// no response waits, as the whole pipeline holds while a response waits;
// reset clears valid bits and loads register defaults, no clearing pass
`default_nettype none

module rk4_damped_pendulum_step_core
   import rk4dp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   rk4dp_req_if.sink        req_chan,
   rk4dp_rsp_if.source      rsp_chan
);

   cfg_type            cfg_ff;
   logic               en;
   logic [1:0]         pre_vld_ff;
   q_type              a1_ff, v1_ff;
   logic signed [65:0] tqp1_ff;
   carry_type          c2_ff;

   logic      acc1_v, acc2_v, acc3_v, acc4_v, adv2_v, adv3_v, adv4_v, fin_v;
   q_type     acc1_dv, acc2_dv, acc3_dv, acc4_dv;
   q_type     adv2_a, adv2_da, adv3_a, adv3_da, adv4_a, adv4_da;
   q_type     fin_a, fin_v_val;
   carry_type acc1_c, acc2_c, acc3_c, acc4_c, adv2_c, adv3_c, adv4_c;
   carry_type k1_c, k2_c, k3_c, k2_in_c, k3_in_c, k4_in_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{step_size: 31'd655, goal_angle: '0, stiffness_ratio: 31'd65536,
                     damping_ratio: '0, gravity_ratio: '0, torque_gain: 32'sd65536};
      end else if (csr_we) begin
         case (csr_index)
            CSR_STEP_SIZE:   cfg_ff.step_size       <= csr_wdata[30:0];
            CSR_GOAL_ANGLE:  cfg_ff.goal_angle      <= csr_wdata;
            CSR_STIFFNESS:   cfg_ff.stiffness_ratio <= csr_wdata[30:0];
            CSR_DAMPING:     cfg_ff.damping_ratio   <= csr_wdata[30:0];
            CSR_GRAVITY:     cfg_ff.gravity_ratio   <= csr_wdata[30:0];
            CSR_TORQUE_GAIN: cfg_ff.torque_gain     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en             = !fin_v || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else if (en) begin
         pre_vld_ff <= {pre_vld_ff[0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff   <= req_chan.angle_in;
         v1_ff   <= req_chan.velocity_in;
         tqp1_ff <= 66'(req_chan.torque_in) * 66'(cfg_ff.torque_gain);
         c2_ff   <= '{a0: a1_ff, v0: v1_ff, tq: qround(tqp1_ff, 1'b0), default: '0};
      end
   end

   // slope bookkeeping between units
   always_comb begin
      k1_c     = acc1_c;
      k1_c.dv1 = acc1_dv;
      k2_in_c     = adv2_c;
      k2_in_c.da2 = adv2_da;
      k2_c     = acc2_c;
      k2_c.dv2 = acc2_dv;
      k3_in_c     = adv3_c;
      k3_in_c.da3 = adv3_da;
      k3_c     = acc3_c;
      k3_c.dv3 = acc3_dv;
      k4_in_c     = adv4_c;
      k4_in_c.da4 = adv4_da;
   end

   rk4dp_accel u_acc1 (
      .clock (clock), .reset (reset), .en (en), .cfg (cfg_ff),
      .valid_in (pre_vld_ff[1]), .a_in (c2_ff.a0), .v_in (c2_ff.v0), .carry_in (c2_ff),
      .valid_out (acc1_v), .acc_out (acc1_dv), .carry_out (acc1_c)
   );

   rk4dp_advance u_adv2 (
      .clock (clock), .reset (reset), .en (en), .cfg (cfg_ff), .half (1'b1),
      .valid_in (acc1_v), .dv_in (acc1_dv), .dap_in (k1_c.v0), .carry_in (k1_c),
      .valid_out (adv2_v), .a_out (adv2_a), .da_out (adv2_da), .carry_out (adv2_c)
   );

   rk4dp_accel u_acc2 (
      .clock (clock), .reset (reset), .en (en), .cfg (cfg_ff),
      .valid_in (adv2_v), .a_in (adv2_a), .v_in (adv2_da), .carry_in (k2_in_c),
      .valid_out (acc2_v), .acc_out (acc2_dv), .carry_out (acc2_c)
   );

   rk4dp_advance u_adv3 (
      .clock (clock), .reset (reset), .en (en), .cfg (cfg_ff), .half (1'b1),
      .valid_in (acc2_v), .dv_in (acc2_dv), .dap_in (k2_c.da2), .carry_in (k2_c),
      .valid_out (adv3_v), .a_out (adv3_a), .da_out (adv3_da), .carry_out (adv3_c)
   );

   rk4dp_accel u_acc3 (
      .clock (clock), .reset (reset), .en (en), .cfg (cfg_ff),
      .valid_in (adv3_v), .a_in (adv3_a), .v_in (adv3_da), .carry_in (k3_in_c),
      .valid_out (acc3_v), .acc_out (acc3_dv), .carry_out (acc3_c)
   );

   rk4dp_advance u_adv4 (
      .clock (clock), .reset (reset), .en (en), .cfg (cfg_ff), .half (1'b0),
      .valid_in (acc3_v), .dv_in (acc3_dv), .dap_in (k3_c.da3), .carry_in (k3_c),
      .valid_out (adv4_v), .a_out (adv4_a), .da_out (adv4_da), .carry_out (adv4_c)
   );

   rk4dp_accel u_acc4 (
      .clock (clock), .reset (reset), .en (en), .cfg (cfg_ff),
      .valid_in (adv4_v), .a_in (adv4_a), .v_in (adv4_da), .carry_in (k4_in_c),
      .valid_out (acc4_v), .acc_out (acc4_dv), .carry_out (acc4_c)
   );

   rk4dp_final u_final (
      .clock (clock), .reset (reset), .en (en), .cfg (cfg_ff),
      .valid_in (acc4_v), .dv4_in (acc4_dv), .carry_in (acc4_c),
      .valid_out (fin_v), .a_out (fin_a), .v_out (fin_v_val)
   );

   assign rsp_chan.valid        = fin_v;
   assign rsp_chan.angle_out    = fin_a;
   assign rsp_chan.velocity_out = fin_v_val;

endmodule

`default_nettype wire

>>> sv/rk4dp_checker.sv
// rk4dp_checker: port-level assertions for the step core, bound to the top
// depends on rk4_damped_pendulum_step_core and its channel interfaces
`default_nettype none

module rk4dp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] angle_out,
   input wire logic [31:0] velocity_out
);

   // nothing left in flight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // pipeline takes a request exactly when the output stage can move
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output stall");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(angle_out) && $stable(velocity_out))
      else $error("stalled response changed");

endmodule

bind rk4_damped_pendulum_step_core rk4dp_checker u_rk4dp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .angle_out    (rsp_chan.angle_out),
   .velocity_out (rsp_chan.velocity_out)
);

`default_nettype wire

>>> verif/rk4_damped_pendulum_step_core_tb.sv
// rk4_damped_pendulum_step_core_tb: self-checking bench for the rk4 pendulum step core
// predicts each step with a local q16.16 rk4 computation; needs rk4dp_pkg and rk4dp_if
`timescale 1ns / 100ps

module rk4_damped_pendulum_step_core_tb;
   import rk4dp_pkg::*;

   localparam int LATENCY = 102;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_STALL = 300;

   typedef struct {
      logic signed [31:0] angle;
      logic signed [31:0] velocity;
   } pend_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   rk4dp_req_if req_chan ();
   rk4dp_rsp_if rsp_chan ();

   rk4_damped_pendulum_step_core dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model registers
   longint m_step, m_goal, m_stiff, m_damp, m_grav, m_gain;

   pend_state_type next_state_q[$];
   int mismatches = 0;
   int checked = 0;
   int sent = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   bit allow_idle = 1;
   int hold_off = 0;
   int stall_left = 0;
   logic long_stall_start = 1'b0;

   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint fxmul(longint a, longint b, int s);
      longint p;
      p = a * b + (64'sd1 <<< (s - 1));
      return clamp32(p >>> s);
   endfunction

   function automatic longint fx_sine(longint d);
      longint r, x2, t;
      r = d % Q_TWO_PI;
      if (r < 0) r += Q_TWO_PI;
      if (r > Q_PI) r -= Q_TWO_PI;
      if (r > Q_HALF_PI) r = Q_PI - r;
      else if (r < -Q_HALF_PI) r = -Q_PI - r;
      x2 = fxmul(r, r, FRAC_BITS);
      t = Q_ONE - x2 / 72;
      t = Q_ONE - fxmul(x2, t, FRAC_BITS) / 42;
      t = Q_ONE - fxmul(x2, t, FRAC_BITS) / 20;
      t = Q_ONE - fxmul(x2, t, FRAC_BITS) / 6;
      return fxmul(r, t, FRAC_BITS);
   endfunction

   function automatic longint pend_accel(longint a, longint v, longint tq);
      longint g, k, dm;
      g = fxmul(m_grav, fx_sine(a - m_goal), FRAC_BITS);
      k = fxmul(clamp32(m_goal - a), m_stiff, FRAC_BITS);
      dm = fxmul(v, m_damp, FRAC_BITS);
      return clamp32(-g - tq + k - dm);
   endfunction

   function automatic pend_state_type rk4_advance(longint a, longint v, longint torque);
      longint tq, h, da2, da3, da4, dv1, dv2, dv3, dv4, sa, sv;
      pend_state_type o;
      tq = fxmul(torque, m_gain, FRAC_BITS);
      h = m_step;
      dv1 = pend_accel(a, v, tq);
      da2 = clamp32(v + fxmul(dv1, h, FRAC_BITS + 1));
      dv2 = pend_accel(clamp32(a + fxmul(v, h, FRAC_BITS + 1)), da2, tq);
      da3 = clamp32(v + fxmul(dv2, h, FRAC_BITS + 1));
      dv3 = pend_accel(clamp32(a + fxmul(da2, h, FRAC_BITS + 1)), da3, tq);
      da4 = clamp32(v + fxmul(dv3, h, FRAC_BITS));
      dv4 = pend_accel(clamp32(a + fxmul(da3, h, FRAC_BITS)), da4, tq);
      sa = (v + 2 * da2 + 2 * da3 + da4) / 6;
      sv = (dv1 + 2 * dv2 + 2 * dv3 + dv4) / 6;
      o.angle = 32'(clamp32(a + fxmul(sa, h, FRAC_BITS)));
      o.velocity = 32'(clamp32(v + fxmul(sv, h, FRAC_BITS)));
      return o;
   endfunction

   task automatic load_defaults();
      m_step = 655; m_goal = 0; m_stiff = 65536;
      m_damp = 0; m_grav = 0; m_gain = 65536;
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_STEP_SIZE:   m_step = longint'(val[30:0]);
         CSR_GOAL_ANGLE:  m_goal = longint'(signed'(val));
         CSR_STIFFNESS:   m_stiff = longint'(val[30:0]);
         CSR_DAMPING:     m_damp = longint'(val[30:0]);
         CSR_GRAVITY:     m_grav = longint'(val[30:0]);
         CSR_TORQUE_GAIN: m_gain = longint'(signed'(val));
         default: ;
      endcase
   endtask

   task automatic set_all(logic [31:0] h, logic [31:0] goal, logic [31:0] k,
                          logic [31:0] d, logic [31:0] g, logic [31:0] gain);
      csr_write(CSR_STEP_SIZE, h);
      csr_write(CSR_GOAL_ANGLE, goal);
      csr_write(CSR_STIFFNESS, k);
      csr_write(CSR_DAMPING, d);
      csr_write(CSR_GRAVITY, g);
      csr_write(CSR_TORQUE_GAIN, gain);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (next_state_q.size() != 0 && !timed_out) @(posedge clock);
   endtask

   task automatic send_step(logic [31:0] a, logic [31:0] v, logic [31:0] tq);
      int gap;
      if (allow_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.angle_in <= a;
      req_chan.velocity_in <= v;
      req_chan.torque_in <= tq;
      next_state_q.push_back(rk4_advance(longint'(signed'(a)), longint'(signed'(v)),
                                         longint'(signed'(tq))));
      do @(posedge clock); while (!req_chan.ready);
      sent++;
   endtask

   function automatic logic [31:0] rand_q(int mag);
      // mag 0: full range, else small values around zero
      if (mag == 0) return $urandom;
      return 32'($signed($urandom_range(0, 2 * mag)) - mag);
   endfunction

   // long receiver hold-off counter
   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left <= stall_left - 1;
      else if (long_stall_start)
         stall_left <= LONG_STALL;
   end

   // response side: random stalls and an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_chan.ready <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 7) == 0) begin
         hold_off <= $urandom_range(0, 3);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pend_state_type exp_s;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (next_state_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: angle %0d velocity %0d",
                        rsp_chan.angle_out, rsp_chan.velocity_out);
         end else begin
            exp_s = next_state_q.pop_front();
            checked++;
            if (exp_s.angle !== rsp_chan.angle_out ||
                exp_s.velocity !== rsp_chan.velocity_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: angle exp %0d got %0d, velocity exp %0d got %0d",
                           exp_s.angle, rsp_chan.angle_out,
                           exp_s.velocity, rsp_chan.velocity_out);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("watchdog expired");
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic test_directed();
      logic [31:0] ext[6];
      ext = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h00010000};
      load_defaults();
      for (int i = 0; i < 6; i++) send_step(ext[i], ext[(i + 2) % 6], ext[(i + 4) % 6]);
      drain();
      set_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h80000000);
      for (int i = 0; i < 6; i++) send_step(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6]);
      drain();
      set_all(32'h0, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h7fffffff);
      send_step(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_step(32'h80000000, 32'h80000000, 32'h80000000);
      drain();
      // gravity with light damping: sine folding near plus and minus pi and half pi
      set_all(32'd6554, 32'h0, 32'h0, 32'd1000, 32'd642000, 32'h0);
      send_step(32'(Q_PI), 32'h0, 32'h0);
      send_step(32'(-Q_PI), 32'h0, 32'h0);
      send_step(32'(Q_HALF_PI + 1), 32'h0, 32'h0);
      send_step(32'(-Q_HALF_PI - 1), 32'h0, 32'h0);
      send_step(32'(Q_TWO_PI * 3), 32'd100, 32'd5);
      drain();
      // unused register index is ignored
      csr_write(csr_index_type'(3'd7), 32'hffffffff);
      send_step(32'd70000, 32'd300, 32'd20);
      drain();
   endtask

   task automatic test_random(int n, bit wide);
      int kind;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 9);
         if (wide || kind == 0)
            send_step(rand_q(0), rand_q(0), rand_q(0));
         else
            send_step(rand_q(500000), rand_q(300000), rand_q(100000));
      end
      drain();
   endtask

   task automatic random_config(bit wide);
      if (wide)
         set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
         set_all($urandom_range(0, 20000), rand_q(300000), $urandom_range(0, 400000),
                 $urandom_range(0, 100000), $urandom_range(0, 700000), rand_q(200000));
   endtask

   task automatic test_backpressure();
      fork
         begin
            @(posedge clock);
            long_stall_start <= 1'b1;
            @(posedge clock);
            long_stall_start <= 1'b0;
         end
         test_random(200, 0);
      join
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.angle_in = '0;
      req_chan.velocity_in = '0;
      req_chan.torque_in = '0;
      load_defaults();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      for (int p = 0; p < 10; p++) begin
         random_config(p % 4 == 3);
         test_random(110, p % 5 == 4);
      end
      test_backpressure();
      allow_idle = 0;
      random_config(0);
      test_random(350, 0);
      repeat (LATENCY + 20) @(posedge clock);
      $display("sent %0d steps over 15 register settings, checked %0d responses", sent,
               checked);
      $display("covered extreme registers, sine folding, saturation and a long stall");
      if (mismatches == 0 && next_state_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
